@@ rtl/core/cdq_pkg.sv @@
// ----------------------------------------------------------------------------
// cdq_pkg
// Types and codes shared by the deque cells, the back-end reduction tree and
// the top level.
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int DATA_W = 32;
  localparam int OCC_W  = 8;

  typedef enum logic [1:0] {
    ACT_PUSH_FRONT = 2'd0,
    ACT_PUSH_BACK  = 2'd1,
    ACT_POP_FRONT  = 2'd2,
    ACT_POP_BACK   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    action_t                   action;
    logic signed [DATA_W-1:0]  push_value;
  } req_t;

  typedef struct packed {
    status_t                   status;
    logic signed [DATA_W-1:0]  popped_value;
    logic [OCC_W-1:0]          occupancy;
  } rsp_t;

  // broadcast to every cell; at most one is set in a cycle
  typedef struct packed {
    logic push_front;
    logic pop_front;
    logic push_back;
    logic pop_back;
  } cell_ctrl_t;

endpackage

@@ rtl/core/cdq_cell.sv @@
// ----------------------------------------------------------------------------
// cdq_cell
// One slot of the deque. Elements stay packed from cell 0 (front) upward;
// front operations shift the whole row, back operations touch only the cell
// at the boundary between occupied and free slots.
// ----------------------------------------------------------------------------
module cdq_cell
  import cdq_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  cell_ctrl_t                ctrl,
  input  logic signed [DATA_W-1:0]  push_value,
  input  logic signed [DATA_W-1:0]  left_data,
  input  logic                      left_valid,
  input  logic signed [DATA_W-1:0]  right_data,
  input  logic                      right_valid,
  output logic signed [DATA_W-1:0]  data,
  output logic                      valid,
  output logic signed [DATA_W-1:0]  tap
);

  logic is_last;
  logic is_first_free;

  assign is_last       = valid & ~right_valid;
  assign is_first_free = ~valid & left_valid;

  // only the back element feeds the reduction tree
  assign tap = is_last ? data : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.push_front) begin
      valid <= left_valid;
    end else if (ctrl.pop_front) begin
      valid <= right_valid;
    end else if (ctrl.push_back && is_first_free) begin
      valid <= 1'b1;
    end else if (ctrl.pop_back && is_last) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push_front) begin
      data <= left_data;
    end else if (ctrl.pop_front) begin
      data <= right_data;
    end else if (ctrl.push_back && is_first_free) begin
      data <= push_value;
    end
  end

endmodule

@@ rtl/core/cdq_tree.sv @@
// ----------------------------------------------------------------------------
// cdq_tree
// Registered OR tree over the cell taps. At most one tap is nonzero, so the
// root settles to the back element once the taps stop moving and the value has passed every level.
// ----------------------------------------------------------------------------
module cdq_tree
  import cdq_pkg::*;
#(
  parameter int LEAVES = 128
) (
  input  logic                      clk,
  input  logic signed [DATA_W-1:0]  leaf [LEAVES],
  output logic signed [DATA_W-1:0]  root
);

  localparam int LEVELS = (LEAVES > 1) ? $clog2(LEAVES) : 1;
  localparam int N      = 1 << LEVELS;

  // heap layout: node 1 is the root, children of j are 2j and 2j+1
  logic signed [DATA_W-1:0] node [1:N-1];

  for (genvar j = 1; j < N; j++) begin : g_node
    logic signed [DATA_W-1:0] lo;
    logic signed [DATA_W-1:0] hi;

    if (2 * j >= N) begin : g_bottom
      if (2 * j - N < LEAVES) begin : g_lo
        assign lo = leaf[2*j-N];
      end else begin : g_lo_pad
        assign lo = '0;
      end
      if (2 * j + 1 - N < LEAVES) begin : g_hi
        assign hi = leaf[2*j+1-N];
      end else begin : g_hi_pad
        assign hi = '0;
      end
    end else begin : g_inner
      assign lo = node[2*j];
      assign hi = node[2*j+1];
    end

    always_ff @(posedge clk) begin
      node[j] <= lo | hi;
    end
  end

  assign root = node[1];

endmodule

@@ rtl/core/circular_deque.sv @@
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue of DEPTH signed 32-bit elements held in a row of cells.
// ----------------------------------------------------------------------------
// Every request gives one response. Pushes, front pops and every rejected
// request (push when full, pop when empty) load the response register as
// they are taken; the next request can enter once that response is taken.
// A successful back pop answers only after the back element is gathered from
// the cell row through a registered OR tree of $clog2(DEPTH) levels; no new
// request enters meanwhile. One request is in flight at a time; the response
// register lets a new request enter in the same cycle that the previous
// response is taken. Element storage and the response payload have no reset;
// state, occupancy, scan counter, rsp_valid and cell valid bits are cleared.
module circular_deque
  import cdq_pkg::*;
#(
  parameter int DEPTH = 128
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int LEVELS = $clog2(DEPTH);
  localparam int SCAN_W = $clog2(LEVELS + 1);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  state_t                   state;
  logic [CNT_W-1:0]         count;
  logic [SCAN_W-1:0]        scan_cnt;

  logic                     accept;
  logic                     full;
  logic                     empty;
  logic                     scan_done;
  logic                     rsp_load;
  logic [CNT_W-1:0]         count_inc;
  logic [CNT_W-1:0]         count_dec;
  cell_ctrl_t               ctrl;

  logic signed [DATA_W-1:0] cell_data  [DEPTH];
  logic                     cell_valid [DEPTH];
  logic signed [DATA_W-1:0] cell_tap   [DEPTH];
  logic signed [DATA_W-1:0] back_value;

  assign req_ready = (state == S_IDLE) && (!rsp_valid || rsp_ready);
  assign accept    = req_valid && req_ready;
  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);
  assign count_inc = count + CNT_W'(1);
  assign count_dec = count - CNT_W'(1);
  assign scan_done = (state == S_SCAN) && (scan_cnt == SCAN_W'(LEVELS));
  // every request answers at once except a back pop that has to scan
  assign rsp_load  = (accept && !((req.action == ACT_POP_BACK) && !empty)) || scan_done;

  always_comb begin
    ctrl = '0;
    if (accept) begin
      unique case (req.action)
        ACT_PUSH_FRONT: ctrl.push_front = !full;
        ACT_PUSH_BACK:  ctrl.push_back  = !full;
        ACT_POP_FRONT:  ctrl.pop_front  = !empty;
        ACT_POP_BACK:   ctrl.pop_back   = 1'b0;
      endcase
    end
    // back pop retires once the tree has produced the back element
    if (scan_done) begin
      ctrl.pop_back = 1'b1;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] l_data;
    logic                     l_valid;
    logic signed [DATA_W-1:0] r_data;
    logic                     r_valid;

    if (i == 0) begin : g_front
      assign l_data  = req.push_value;
      assign l_valid = 1'b1;
    end else begin : g_mid_l
      assign l_data  = cell_data[i-1];
      assign l_valid = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_back
      assign r_data  = '0;
      assign r_valid = 1'b0;
    end else begin : g_mid_r
      assign r_data  = cell_data[i+1];
      assign r_valid = cell_valid[i+1];
    end

    cdq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .push_value (req.push_value),
      .left_data  (l_data),
      .left_valid (l_valid),
      .right_data (r_data),
      .right_valid(r_valid),
      .data       (cell_data[i]),
      .valid      (cell_valid[i]),
      .tap        (cell_tap[i])
    );
  end

  cdq_tree #(
    .LEAVES(DEPTH)
  ) u_tree (
    .clk (clk),
    .leaf(cell_tap),
    .root(back_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      count     <= '0;
      scan_cnt  <= '0;
    end else begin
      rsp_valid <= rsp_load || (rsp_valid && !rsp_ready);
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (req.action)
              ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                rsp.popped_value <= '0;
                if (full) begin
                  rsp.status    <= ST_FULL;
                  rsp.occupancy <= OCC_W'(count);
                end else begin
                  rsp.status    <= ST_DONE;
                  rsp.occupancy <= OCC_W'(count_inc);
                  count         <= count_inc;
                end
              end
              ACT_POP_FRONT: begin
                if (empty) begin
                  rsp.status       <= ST_EMPTY;
                  rsp.popped_value <= '0;
                  rsp.occupancy    <= OCC_W'(count);
                end else begin
                  rsp.status       <= ST_DONE;
                  rsp.popped_value <= cell_data[0];
                  rsp.occupancy    <= OCC_W'(count_dec);
                  count            <= count_dec;
                end
              end
              ACT_POP_BACK: begin
                if (empty) begin
                  rsp.status       <= ST_EMPTY;
                  rsp.popped_value <= '0;
                  rsp.occupancy    <= OCC_W'(count);
                end else begin
                  state    <= S_SCAN;
                  scan_cnt <= '0;
                end
              end
            endcase
          end
        end
        S_SCAN: begin
          scan_cnt <= scan_cnt + SCAN_W'(1);
          if (scan_done) begin
            state            <= S_IDLE;
            rsp.status       <= ST_DONE;
            rsp.popped_value <= back_value;
            rsp.occupancy    <= OCC_W'(count_dec);
            count            <= count_dec;
          end
        end
      endcase
    end
  end

endmodule
